// ===== src/dhb_pkg.sv =====
// shared types and constants for the dual h-bridge ramp pwm drive
package dhb_pkg;

   // operation codes of a request
   localparam logic [1:0] OP_SET   = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_BRAKE = 2'd2;

   // configuration register indexes
   localparam int         CSR_INDEX_BITS = 3;
   localparam int         CSR_DATA_BITS  = 17;
   localparam logic [2:0] CSR_RAMP_STEP  = 3'd0;
   localparam logic [2:0] CSR_INPUT_MIN  = 3'd1;
   localparam logic [2:0] CSR_INPUT_MAX  = 3'd2;
   localparam logic [2:0] CSR_MAX_DUTY   = 3'd3;
   localparam logic [2:0] CSR_PWM_WRAP   = 3'd4;

   // configuration register file
   typedef struct packed {
      logic        [7:0]  ramp_step;
      logic signed [7:0]  input_min;
      logic        [6:0]  input_max;
      logic        [16:0] max_duty_q16;
      logic        [15:0] pwm_wrap;
   } dhb_cfg_type;

   localparam dhb_cfg_type CFG_RESET = '{
      ramp_step:    8'd5,
      input_min:    8'h9C,
      input_max:    7'd100,
      max_duty_q16: 17'd65536,
      pwm_wrap:     16'd6249
   };

   // current speeds handed from the front to the level unit
   typedef struct packed {
      logic signed [7:0] left_now;
      logic signed [7:0] right_now;
   } dhb_entry_type;

   // queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } dhb_queue_status_type;

   // level arithmetic: floor(x / 6553600) = floor(floor(x / 65536) / 100)
   localparam int          MAG_BITS    = 8;
   localparam int          DUTY_BITS   = 17;
   localparam int          DUTY_SHIFT  = 16;
   localparam int          RECIP_BITS  = 26;
   localparam int          RECIP_SHIFT = 32;
   localparam logic [25:0] RECIP_100   = 26'd42949673;

   // level unit sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL1,
      BK_MUL2,
      BK_MUL3,
      BK_FINISH,
      BK_HOLD
   } dhb_back_state_type;

endpackage

// ===== src/dhb_req_if.sv =====
// request channel: op code and two requested percents
interface dhb_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  op;
   logic signed [15:0] left_request;
   logic signed [15:0] right_request;

   modport source (output valid, op, left_request, right_request, input ready);
   modport sink   (input valid, op, left_request, right_request, output ready);
endinterface

// ===== src/dhb_rsp_if.sv =====
// result channel: four compare levels and two current speeds
interface dhb_rsp_if;
   logic               valid;
   logic               ready;
   logic        [15:0] left_fwd_level;
   logic        [15:0] left_rev_level;
   logic        [15:0] right_fwd_level;
   logic        [15:0] right_rev_level;
   logic signed [7:0]  left_speed;
   logic signed [7:0]  right_speed;

   modport source (output valid, left_fwd_level, left_rev_level, right_fwd_level,
                   right_rev_level, left_speed, right_speed, input ready);
   modport sink   (input valid, left_fwd_level, left_rev_level, right_fwd_level,
                   right_rev_level, left_speed, right_speed, output ready);
endinterface

// ===== src/dhb_front.sv =====
// front: takes requests, keeps targets and current speeds, queues ticks and brakes
module dhb_front
   import dhb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   dhb_req_if.sink              req_chan,
   input  dhb_cfg_type          cfg,
   input  dhb_queue_status_type q_status,
   output logic                 push,
   output dhb_entry_type        push_data
);

   logic signed [7:0] left_goal_ff, left_goal_in;
   logic signed [7:0] right_goal_ff, right_goal_in;
   logic signed [7:0] left_now_ff, left_now_in;
   logic signed [7:0] right_now_ff, right_now_in;
   logic              accept;

   // clamp a request into the configured range
   function automatic logic signed [7:0] clamp_req(input logic signed [15:0] v,
                                                   input dhb_cfg_type c);
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      lo = {{8{c.input_min[7]}}, c.input_min};
      hi = {9'b0, c.input_max};
      if (v < lo) return lo[7:0];
      if (v > hi) return hi[7:0];
      return v[7:0];
   endfunction

   // move cur toward tgt by at most s
   function automatic logic signed [7:0] step_toward(input logic signed [7:0] cur,
                                                     input logic signed [7:0] tgt,
                                                     input logic        [7:0] s);
      logic signed [9:0] c10;
      logic signed [9:0] t10;
      logic signed [9:0] up;
      logic signed [9:0] dn;
      c10 = {{2{cur[7]}}, cur};
      t10 = {{2{tgt[7]}}, tgt};
      up  = c10 + $signed({2'b00, s});
      dn  = c10 - $signed({2'b00, s});
      if (c10 < t10) return (up > t10) ? tgt : up[7:0];
      if (c10 > t10) return (dn < t10) ? tgt : dn[7:0];
      return cur;
   endfunction

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   // state update per op code
   always_comb begin
      left_goal_in  = left_goal_ff;
      right_goal_in = right_goal_ff;
      left_now_in   = left_now_ff;
      right_now_in  = right_now_ff;
      push          = 1'b0;
      if (accept) begin
         case (req_chan.op)
            OP_SET: begin
               left_goal_in  = clamp_req(req_chan.left_request, cfg);
               right_goal_in = clamp_req(req_chan.right_request, cfg);
            end
            OP_TICK: begin
               left_now_in  = step_toward(left_now_ff, left_goal_ff, cfg.ramp_step);
               right_now_in = step_toward(right_now_ff, right_goal_ff, cfg.ramp_step);
               push         = 1'b1;
            end
            OP_BRAKE: begin
               left_goal_in  = '0;
               right_goal_in = '0;
               left_now_in   = '0;
               right_now_in  = '0;
               push          = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign push_data.left_now  = left_now_in;
   assign push_data.right_now = right_now_in;

   // speed state
   always_ff @(posedge clock) begin
      if (reset) begin
         left_goal_ff  <= '0;
         right_goal_ff <= '0;
         left_now_ff   <= '0;
         right_now_ff  <= '0;
      end else begin
         left_goal_ff  <= left_goal_in;
         right_goal_ff <= right_goal_in;
         left_now_ff   <= left_now_in;
         right_now_ff  <= right_now_in;
      end
   end

endmodule

// ===== src/dhb_queue.sv =====
// short fifo of current speeds between front and level unit
module dhb_queue
   import dhb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dhb_entry_type        push_data,
   input  logic                 pop,
   output dhb_entry_type        pop_data,
   output dhb_queue_status_type status
);

   dhb_entry_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   count_ff, count_in;

   localparam logic [QUEUE_PTR_BITS-1:0] LAST_PTR = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_BITS-1:0] FULL_CNT = QUEUE_CNT_BITS'(QUEUE_DEPTH);

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign pop_data     = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   // fill count stays within depth and no transfer lands on a full queue
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_CNT)
      else $error("queue count above depth");
   assert property (@(posedge clock) disable iff (reset) !(push && status.full))
      else $error("push into full queue");

endmodule

// ===== src/dhb_back.sv =====
// back: turns current speeds into pwm compare levels over a few multiply steps
module dhb_back
   import dhb_pkg::*;
#(
   parameter int LEVEL_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dhb_cfg_type          cfg,
   input  dhb_queue_status_type q_status,
   input  dhb_entry_type        pop_data,
   output logic                 pop,
   dhb_rsp_if.source            rsp_chan
);

   localparam int P1_BITS  = MAG_BITS + DUTY_BITS;
   localparam int P2_BITS  = P1_BITS + LEVEL_BITS;
   localparam int Q_BITS   = P2_BITS - DUTY_SHIFT;
   localparam int P3_BITS  = Q_BITS + RECIP_BITS;
   localparam int LVL_BITS = P3_BITS - RECIP_SHIFT;

   dhb_back_state_type       state_ff, state_in;
   logic                     load_en, mul1_en, mul2_en, mul3_en, out_en;
   logic signed [7:0]        now_ff   [2];
   logic [MAG_BITS-1:0]      mag_ff   [2];
   logic [MAG_BITS-1:0]      mag_in   [2];
   logic [P1_BITS-1:0]       p1_ff    [2];
   logic [P2_BITS-1:0]       p2_ff    [2];
   logic [P3_BITS-1:0]       p3_ff    [2];
   logic [LEVEL_BITS-1:0]    cap_lvl  [2];
   logic [15:0]              fwd_in   [2];
   logic [15:0]              rev_in   [2];
   logic [15:0]              fwd_ff   [2];
   logic [15:0]              rev_ff   [2];
   logic [LEVEL_BITS-1:0]    wrap;
   logic signed [7:0]        now_in   [2];
   logic [8:0]               neg_now  [2];

   assign wrap      = cfg.pwm_wrap[LEVEL_BITS-1:0];
   assign now_in[0] = pop_data.left_now;
   assign now_in[1] = pop_data.right_now;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (!q_status.empty) state_in = BK_MUL1;
         BK_MUL1:   state_in = BK_MUL2;
         BK_MUL2:   state_in = BK_MUL3;
         BK_MUL3:   state_in = BK_FINISH;
         BK_FINISH: state_in = BK_HOLD;
         BK_HOLD:   if (rsp_chan.ready) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      load_en        = 1'b0;
      mul1_en        = 1'b0;
      mul2_en        = 1'b0;
      mul3_en        = 1'b0;
      out_en         = 1'b0;
      rsp_chan.valid = 1'b0;
      case (state_ff)
         BK_IDLE:   load_en        = !q_status.empty;
         BK_MUL1:   mul1_en        = 1'b1;
         BK_MUL2:   mul2_en        = 1'b1;
         BK_MUL3:   mul3_en        = 1'b1;
         BK_FINISH: out_en         = 1'b1;
         BK_HOLD:   rsp_chan.valid = 1'b1;
         default: begin
         end
      endcase
   end

   assign pop = load_en;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else       state_ff <= state_in;
   end

   // per side magnitude, capped level and pin levels
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         neg_now[i] = 9'd0 - {now_in[i][7], now_in[i]};
         mag_in[i]  = now_in[i][7] ? neg_now[i][MAG_BITS-1:0] : now_in[i][MAG_BITS-1:0];
         if (p3_ff[i][P3_BITS-1:RECIP_SHIFT] > LVL_BITS'(wrap)) cap_lvl[i] = wrap;
         else cap_lvl[i] = p3_ff[i][RECIP_SHIFT+LEVEL_BITS-1:RECIP_SHIFT];
         if (now_ff[i] == '0) begin
            fwd_in[i] = 16'(wrap);
            rev_in[i] = 16'(wrap);
         end else if (now_ff[i][7]) begin
            fwd_in[i] = '0;
            rev_in[i] = 16'(cap_lvl[i]);
         end else begin
            fwd_in[i] = 16'(cap_lvl[i]);
            rev_in[i] = '0;
         end
      end
   end

   // multiply steps: magnitude times duty, times wrap, then reciprocal of 100
   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         if (load_en) begin
            now_ff[i] <= now_in[i];
            mag_ff[i] <= mag_in[i];
         end
         if (mul1_en) p1_ff[i] <= P1_BITS'(mag_ff[i]) * P1_BITS'(cfg.max_duty_q16);
         if (mul2_en) p2_ff[i] <= P2_BITS'(p1_ff[i]) * P2_BITS'(wrap);
         if (mul3_en) p3_ff[i] <= P3_BITS'(p2_ff[i][P2_BITS-1:DUTY_SHIFT])
                                  * P3_BITS'(RECIP_100);
         if (out_en) begin
            fwd_ff[i] <= fwd_in[i];
            rev_ff[i] <= rev_in[i];
         end
      end
   end

   assign rsp_chan.left_fwd_level  = fwd_ff[0];
   assign rsp_chan.left_rev_level  = rev_ff[0];
   assign rsp_chan.right_fwd_level = fwd_ff[1];
   assign rsp_chan.right_rev_level = rev_ff[1];
   assign rsp_chan.left_speed      = now_ff[0];
   assign rsp_chan.right_speed     = now_ff[1];

   // left fwd, right rev <= wrap; zero left speed gives brake level on both pins
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.left_fwd_level <= 16'(wrap)
                          && rsp_chan.right_rev_level <= 16'(wrap)))
      else $error("level above wrap");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.left_speed == '0)
         |-> (rsp_chan.left_fwd_level == rsp_chan.left_rev_level))
      else $error("zero speed without brake levels");

endmodule

// ===== src/dual_hbridge_ramp_pwm_drive_top.sv =====
// top level: config registers, request front, speed queue and level unit
// path: a tick or brake transfer is queued; the level unit pops one entry at a time and
// runs its three multiply steps and FINISH, then holds the result until it is taken
// set and unused op codes give no result; requests are taken while the queue is not full
// reset: synchronous; targets and speeds clear to zero, registers take their defaults
module dual_hbridge_ramp_pwm_drive_top
   import dhb_pkg::*;
#(
   parameter int LEVEL_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   dhb_req_if.sink                   req_chan,
   dhb_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   dhb_cfg_type          cfg_ff, cfg_in;
   dhb_queue_status_type q_status;
   dhb_entry_type        push_data;
   dhb_entry_type        pop_data;
   logic                 push;
   logic                 pop;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RAMP_STEP: cfg_in.ramp_step    = csr_wdata[7:0];
            CSR_INPUT_MIN: cfg_in.input_min    = csr_wdata[7:0];
            CSR_INPUT_MAX: cfg_in.input_max    = csr_wdata[6:0];
            CSR_MAX_DUTY:  cfg_in.max_duty_q16 = csr_wdata[16:0];
            CSR_PWM_WRAP:  cfg_in.pwm_wrap     = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= CFG_RESET;
      else       cfg_ff <= cfg_in;
   end

   dhb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   dhb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   dhb_back #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== dv/dhb_drive_checker.sv =====
`timescale 1ns / 1ps
// drive checker: follows both channels and the register port, predicts and compares levels
module dhb_drive_checker
   import dhb_pkg::*;
#(
   parameter int LEVEL_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   dhb_req_if                        req_mon,
   dhb_rsp_if                        rsp_mon,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        pending_count
);

   // one expected result transfer
   typedef struct packed {
      logic        [15:0] left_fwd;
      logic        [15:0] left_rev;
      logic        [15:0] right_fwd;
      logic        [15:0] right_rev;
      logic signed [7:0]  left_speed;
      logic signed [7:0]  right_speed;
   } drive_levels_type;

   localparam longint unsigned LEVEL_DIVISOR = 64'd6553600;
   localparam longint unsigned LEVEL_MASK    = (64'd1 << LEVEL_BITS) - 64'd1;

   dhb_cfg_type       drive_cfg;
   logic signed [7:0] left_goal;
   logic signed [7:0] right_goal;
   logic signed [7:0] left_now;
   logic signed [7:0] right_now;
   drive_levels_type  levels_due[$];
   int                errors = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // request percent limited to the configured range; if crossed, min wins only below min
   function automatic logic signed [7:0] bound_request(input logic signed [15:0] request,
                                                       input dhb_cfg_type cfg);
      int value;
      value = int'($signed(request));
      if (value < int'($signed(cfg.input_min))) return cfg.input_min;
      if (value > int'(cfg.input_max)) return 8'(cfg.input_max);
      return 8'(value);
   endfunction

   // slew-limited move of the current percent toward its target
   function automatic logic signed [7:0] ramp_toward(input logic signed [7:0] now_pct,
                                                     input logic signed [7:0] goal_pct,
                                                     input logic [7:0] step);
      int cur;
      int goal;
      int moved;
      cur   = int'($signed(now_pct));
      goal  = int'($signed(goal_pct));
      moved = cur;
      if (cur < goal) begin
         moved = cur + int'(step);
         if (moved > goal) moved = goal;
      end else if (cur > goal) begin
         moved = cur - int'(step);
         if (moved < goal) moved = goal;
      end
      return 8'(moved);
   endfunction

   // compare levels of one bridge; zero speed is active brake at wrap
   function automatic void side_levels(input logic signed [7:0] pct, input dhb_cfg_type cfg,
                                       output logic [15:0] fwd, output logic [15:0] rev);
      longint unsigned wrap_lvl;
      longint unsigned mag;
      longint unsigned duty;
      longint unsigned lvl;
      int              pct_int;
      pct_int  = int'($signed(pct));
      wrap_lvl = cfg.pwm_wrap;
      wrap_lvl = wrap_lvl & LEVEL_MASK;
      duty     = cfg.max_duty_q16;
      if (pct_int == 0) begin
         fwd = 16'(wrap_lvl);
         rev = 16'(wrap_lvl);
         return;
      end
      mag = (pct_int < 0) ? -pct_int : pct_int;
      lvl = mag * duty * wrap_lvl / LEVEL_DIVISOR;
      if (lvl > wrap_lvl) lvl = wrap_lvl;
      if (pct_int > 0) begin
         fwd = 16'(lvl);
         rev = 16'd0;
      end else begin
         fwd = 16'd0;
         rev = 16'(lvl);
      end
   endfunction

   always @(posedge clock) begin
      drive_levels_type want;
      if (reset) begin
         drive_cfg  = CFG_RESET;
         left_goal  = '0;
         right_goal = '0;
         left_now   = '0;
         right_now  = '0;
         levels_due.delete();
      end else begin
         // register writes; indexes past the list do nothing
         if (csr_we) begin
            case (csr_index)
               CSR_RAMP_STEP: drive_cfg.ramp_step    = csr_wdata[7:0];
               CSR_INPUT_MIN: drive_cfg.input_min    = csr_wdata[7:0];
               CSR_INPUT_MAX: drive_cfg.input_max    = csr_wdata[6:0];
               CSR_MAX_DUTY:  drive_cfg.max_duty_q16 = csr_wdata[16:0];
               CSR_PWM_WRAP:  drive_cfg.pwm_wrap     = csr_wdata[15:0];
               default: ;
            endcase
         end

         // result transfer against the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (levels_due.size() == 0) begin
               report_mismatch($sformatf("result with none expected, speeds %0d/%0d",
                                         rsp_mon.left_speed, rsp_mon.right_speed));
            end else begin
               want = levels_due.pop_front();
               check_field("left_fwd_level", int'(rsp_mon.left_fwd_level),
                           int'(want.left_fwd));
               check_field("left_rev_level", int'(rsp_mon.left_rev_level),
                           int'(want.left_rev));
               check_field("right_fwd_level", int'(rsp_mon.right_fwd_level),
                           int'(want.right_fwd));
               check_field("right_rev_level", int'(rsp_mon.right_rev_level),
                           int'(want.right_rev));
               check_field("left_speed", int'($signed(rsp_mon.left_speed)),
                           int'($signed(want.left_speed)));
               check_field("right_speed", int'($signed(rsp_mon.right_speed)),
                           int'($signed(want.right_speed)));
            end
         end

         // request transfer advances targets and speeds
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.op)
               OP_SET: begin
                  left_goal  = bound_request(req_mon.left_request, drive_cfg);
                  right_goal = bound_request(req_mon.right_request, drive_cfg);
               end
               OP_TICK, OP_BRAKE: begin
                  if (req_mon.op == OP_TICK) begin
                     left_now  = ramp_toward(left_now, left_goal, drive_cfg.ramp_step);
                     right_now = ramp_toward(right_now, right_goal, drive_cfg.ramp_step);
                  end else begin
                     left_goal  = '0;
                     right_goal = '0;
                     left_now   = '0;
                     right_now  = '0;
                  end
                  side_levels(left_now, drive_cfg, want.left_fwd, want.left_rev);
                  side_levels(right_now, drive_cfg, want.right_fwd, want.right_rev);
                  want.left_speed  = left_now;
                  want.right_speed = right_now;
                  levels_due.push_back(want);
               end
               default: ;
            endcase
         end
      end
      pending_count <= levels_due.size();
      fail_count    <= errors;
   end

endmodule

// ===== dv/tb_dual_hbridge_ramp_pwm_drive_top.sv =====
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus, register phases and verdict for the drive
module tb_dual_hbridge_ramp_pwm_drive_top;
   import dhb_pkg::*;

   localparam int         LEVEL_BITS       = 16;
   localparam int         WATCHDOG_LIMIT   = 2000;
   localparam int         DRAIN_CYCLES     = 10;
   localparam int         RANDOM_PER_PHASE = 110;
   localparam logic [1:0] OP_UNUSED        = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   int                        fail_count;
   int                        pending_count;
   int                        idle_cycles = 0;
   bit                        gaps_on = 1'b1;

   dhb_req_if drive_req ();
   dhb_rsp_if drive_rsp ();

   dual_hbridge_ramp_pwm_drive_top #(.LEVEL_BITS(LEVEL_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (drive_req),
      .rsp_chan  (drive_rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dhb_drive_checker #(.LEVEL_BITS(LEVEL_BITS)) drive_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (drive_req),
      .rsp_mon       (drive_rsp),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: ready stalls in bursts
   initial begin
      forever begin
         if (gaps_on && $urandom_range(0, 2) == 0) begin
            drive_rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            drive_rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (drive_req.valid && drive_req.ready) || (drive_rsp.valid && drive_rsp.ready))
      begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one request transfer, with an optional gap ahead of it
   task automatic send_request(input logic [1:0] op, input logic signed [15:0] left_pct,
                               input logic signed [15:0] right_pct);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         drive_req.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      drive_req.valid         <= 1'b1;
      drive_req.op            <= op;
      drive_req.left_request  <= left_pct;
      drive_req.right_request <= right_pct;
      do @(posedge clock); while (!drive_req.ready);
   endtask

   // hold requests until every expected result is back and the block settles
   task automatic drain_results();
      drive_req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   function automatic dhb_cfg_type random_settings();
      dhb_cfg_type cfg;
      cfg.ramp_step    = 8'($urandom_range(1, 200));
      cfg.input_min    = 8'(-int'($urandom_range(0, 100)));
      cfg.input_max    = 7'($urandom_range(0, 100));
      cfg.max_duty_q16 = 17'($urandom_range(0, 65536));
      cfg.pwm_wrap     = 16'($urandom);
      return cfg;
   endfunction

   // mostly near the percent range, some full-width and end values
   function automatic logic signed [15:0] random_percent();
      case ($urandom_range(0, 9))
         0, 1, 2: return 16'($urandom);
         3:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default: return 16'(int'($urandom_range(0, 260)) - 130);
      endcase
   endfunction

   // idle block: new settings, then set-and-ramp sequences mixed with noise
   task automatic run_phase(input dhb_cfg_type cfg);
      int sent;
      int ticks;
      drain_results();
      write_reg(CSR_RAMP_STEP, {9'd0, cfg.ramp_step});
      write_reg(CSR_INPUT_MIN, {9'd0, cfg.input_min});
      write_reg(CSR_INPUT_MAX, {10'd0, cfg.input_max});
      write_reg(CSR_MAX_DUTY, cfg.max_duty_q16);
      write_reg(CSR_PWM_WRAP, {1'b0, cfg.pwm_wrap});
      for (int i = int'(CSR_PWM_WRAP) + 1; i < (1 << CSR_INDEX_BITS); i++)
         write_reg(CSR_INDEX_BITS'(i), CSR_DATA_BITS'($urandom));
      csr_we <= 1'b0;
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
         if (gaps_on && $urandom_range(0, 59) == 0) drain_results();
         if ($urandom_range(0, 9) < 7) begin
            send_request(OP_SET, random_percent(), random_percent());
            ticks = $urandom_range(1, 12);
            repeat (ticks) send_request(OP_TICK, 16'($urandom), 16'($urandom));
            sent += ticks + 1;
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  send_request(OP_BRAKE, 16'($urandom), 16'($urandom));
                  sent++;
               end
               1: send_request(OP_UNUSED, 16'($urandom), 16'($urandom));
               default: begin
                  send_request(OP_TICK, 16'($urandom), 16'($urandom));
                  sent++;
               end
            endcase
         end
      end
   endtask

   initial begin
      dhb_cfg_type cfg;
      reset                   <= 1'b1;
      csr_we                  <= 1'b0;
      csr_index               <= '0;
      csr_wdata               <= '0;
      drive_req.valid         <= 1'b0;
      drive_req.op            <= OP_SET;
      drive_req.left_request  <= '0;
      drive_req.right_request <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed items at reset settings
      send_request(OP_TICK, 16'sd0, 16'sd0);
      send_request(OP_SET, 16'sd100, -16'sd100);
      repeat (3) send_request(OP_TICK, 16'sd0, 16'sd0);
      // clamping at both ends of the request range
      send_request(OP_SET, 16'sh7FFF, 16'sh8000);
      repeat (2) send_request(OP_TICK, 16'shFFFF, 16'sh0000);
      send_request(OP_SET, 16'sh8000, 16'sh7FFF);
      repeat (3) send_request(OP_TICK, 16'sh0000, 16'shFFFF);
      // unused op code leaves state alone
      send_request(OP_UNUSED, 16'sh7FFF, 16'sh8000);
      send_request(OP_TICK, 16'sd0, 16'sd0);
      send_request(OP_BRAKE, 16'sh5555, 16'shAAAA);
      send_request(OP_TICK, 16'sd0, 16'sd0);
      send_request(OP_SET, 16'sd37, -16'sd58);
      repeat (4) send_request(OP_TICK, 16'sd0, 16'sd0);
      send_request(OP_SET, -16'sd1, 16'sd1);
      send_request(OP_TICK, 16'sd0, 16'sd0);
      send_request(OP_BRAKE, 16'sd0, 16'sd0);

      // all register bits set but the sign of the minimum, duty above full
      cfg = '{ramp_step: 8'hFF, input_min: 8'sh7F, input_max: 7'h7F,
              max_duty_q16: 17'h1FFFF, pwm_wrap: 16'hFFFF};
      run_phase(cfg);
      // all zero: speeds frozen, levels zero
      cfg = '{ramp_step: 8'h00, input_min: 8'sh00, input_max: 7'h00,
              max_duty_q16: 17'h00000, pwm_wrap: 16'h0000};
      run_phase(cfg);
      // crossed limits
      cfg = '{ramp_step: 8'd7, input_min: 8'sd50, input_max: 7'd20,
              max_duty_q16: 17'd65536, pwm_wrap: 16'd6249};
      run_phase(cfg);
      // most negative minimum, small wrap
      cfg = '{ramp_step: 8'd200, input_min: 8'sh80, input_max: 7'd0,
              max_duty_q16: 17'd66536, pwm_wrap: 16'd1000};
      run_phase(cfg);
      run_phase(random_settings());
      run_phase(random_settings());
      // final stretch without random gaps or ready stalls
      gaps_on = 1'b0;
      run_phase(CFG_RESET);

      drain_results();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== dual_hbridge_ramp_pwm_drive_top.f =====
src/dhb_pkg.sv
src/dhb_req_if.sv
src/dhb_rsp_if.sv
src/dhb_front.sv
src/dhb_queue.sv
src/dhb_back.sv
src/dual_hbridge_ramp_pwm_drive_top.sv
dv/dhb_drive_checker.sv
dv/tb_dual_hbridge_ramp_pwm_drive_top.sv
